>>> rtl/core/frbt_pkg.sv
// frbt_pkg: shared types and constants for the framed byte receiver
// no dependencies
`default_nettype none

package frbt_pkg;

  localparam int BYTE_W    = 8;
  localparam int TICK_W    = 16;
  localparam int OP_W      = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY = 2'd2;

  localparam logic [TICK_W-1:0] TIMEOUT_RST = 16'd10;
  localparam logic [BYTE_W-1:0] MIN_PAY_RST = 8'd2;
  localparam logic [BYTE_W-1:0] MAX_PAY_RST = 8'd253;
  localparam logic [TICK_W-1:0] TICK_MAX    = 16'hffff;
  localparam logic [BYTE_W:0]   HDR_LEN     = 9'd2;

  // buffer write request from the receive control
  typedef struct packed {
    logic              en;
    logic              bank;
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] data;
  } rx_wr_t;

  // status after the current transaction, plus the readable bank
  typedef struct packed {
    logic              committed;
    logic              skipping;
    logic [BYTE_W-1:0] msg_count;
    logic              rd_bank;
  } rx_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/frbt_ifs.sv
// frbt_ifs: valid/ready channel interfaces for input and result transactions
// depends on frbt_pkg
`default_nettype none

interface frbt_in_if import frbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [BYTE_W-1:0] data_byte;
  logic [BYTE_W-1:0] read_index;

  modport source (output valid, operation, data_byte, read_index, input ready);
  modport sink   (input valid, operation, data_byte, read_index, output ready);
endinterface

interface frbt_out_if import frbt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic              frame_committed;
  logic [BYTE_W-1:0] committed_count;
  logic              skipping;

  modport source (output valid, read_data, frame_committed, committed_count, skipping,
                  input ready);
  modport sink   (input valid, read_data, frame_committed, committed_count, skipping,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/frbt_rx_ctrl.sv
// frbt_rx_ctrl: frame parsing, idle timeout, config registers and bank select
// depends on frbt_pkg
`default_nettype none

module frbt_rx_ctrl
  import frbt_pkg::*;
#(
  parameter int MAX_FRAME_LEN = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  logic [OP_W-1:0]      operation,
  input  logic [BYTE_W-1:0]    data_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output rx_wr_t               wr,
  output rx_stat_t             stat
);

  localparam logic [BYTE_W-1:0] MAX_POS = BYTE_W'(MAX_FRAME_LEN);

  logic [TICK_W-1:0] timeout_r;
  logic [BYTE_W-1:0] min_pay_r;
  logic [BYTE_W-1:0] max_pay_r;

  logic [BYTE_W-1:0] pos_r, pos_nxt;
  logic [BYTE_W-1:0] len_r, len_nxt;
  logic              skip_r, skip_nxt;
  logic              complete_r, complete_nxt;
  logic [BYTE_W-1:0] stored_r, stored_nxt;
  logic [TICK_W-1:0] idle_r, idle_nxt;
  logic              bank_r, bank_nxt;
  logic [BYTE_W-1:0] msg_cnt_r, msg_cnt_nxt;
  logic              commit;
  logic              wr_en;
  op_t               op;

  assign op = op_t'(operation);

  always_comb begin
    pos_nxt      = pos_r;
    len_nxt      = len_r;
    skip_nxt     = skip_r;
    complete_nxt = complete_r;
    stored_nxt   = stored_r;
    idle_nxt     = idle_r;
    bank_nxt     = bank_r;
    msg_cnt_nxt  = msg_cnt_r;
    commit       = 1'b0;
    wr_en        = 1'b0;
    case (op)
      OP_BYTE: begin
        if (!skip_r) begin
          idle_nxt = '0;
          if (pos_r < MAX_POS) begin
            if (pos_r == '0) begin
              if (data_byte > 8'd1) skip_nxt = 1'b1;
            end else if (pos_r == 8'd1) begin
              if (data_byte >= min_pay_r && data_byte <= max_pay_r) len_nxt = data_byte;
              else skip_nxt = 1'b1;
            end else if (stored_r < MAX_POS) begin
              wr_en      = 1'b1;
              stored_nxt = stored_r + 8'd1;
            end
            pos_nxt = pos_r + 8'd1;
            if (!skip_nxt && pos_nxt >= 8'd2 &&
                {1'b0, pos_nxt} >= ({1'b0, len_nxt} + HDR_LEN)) complete_nxt = 1'b1;
            if (pos_nxt >= MAX_POS) complete_nxt = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (idle_r != TICK_MAX) idle_nxt = idle_r + 16'd1;
        if (idle_nxt >= timeout_r) begin
          if (complete_r) begin
            commit      = 1'b1;
            bank_nxt    = ~bank_r;
            msg_cnt_nxt = stored_r;
          end
          pos_nxt      = '0;
          len_nxt      = '0;
          skip_nxt     = 1'b0;
          complete_nxt = 1'b0;
          stored_nxt   = '0;
          idle_nxt     = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      min_pay_r <= MIN_PAY_RST;
      max_pay_r <= MAX_PAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_r <= cfg_wdata;
        CFG_MIN_PAY: min_pay_r <= cfg_wdata[BYTE_W-1:0];
        CFG_MAX_PAY: max_pay_r <= cfg_wdata[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      len_r      <= '0;
      skip_r     <= 1'b0;
      complete_r <= 1'b0;
      stored_r   <= '0;
      idle_r     <= '0;
      bank_r     <= 1'b0;
      msg_cnt_r  <= '0;
    end else if (fire) begin
      pos_r      <= pos_nxt;
      len_r      <= len_nxt;
      skip_r     <= skip_nxt;
      complete_r <= complete_nxt;
      stored_r   <= stored_nxt;
      idle_r     <= idle_nxt;
      bank_r     <= bank_nxt;
      msg_cnt_r  <= msg_cnt_nxt;
    end
  end

  // receive side writes the bank not being read
  assign wr.en   = fire && wr_en;
  assign wr.bank = ~bank_r;
  assign wr.idx  = stored_r;
  assign wr.data = data_byte;

  assign stat.committed = commit;
  assign stat.skipping  = skip_nxt;
  assign stat.msg_count = msg_cnt_nxt;
  assign stat.rd_bank   = bank_r;

  a_stored_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= pos_r)
    else $error("stored count ran ahead of byte position");

  a_skip_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r |-> !complete_r)
    else $error("frame complete while skipping");

  a_commit_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && commit) |=> (pos_r == '0 && stored_r == '0 && bank_r != $past(bank_r)))
    else $error("commit did not restart receiver and swap banks");

endmodule

`default_nettype wire

>>> rtl/core/framed_byte_receiver_with_timeout.sv
// Framed byte receiver with idle timeout. One transaction per clock, accepted
// back to back unless the result stalls; each transaction's result appears
// in the cycle after acceptance, registered by the frame memory's read port.
// The memory holds two banks: one fills with payload bytes while the other
// serves reads; a commit swaps them, so commit and restart need no copy and no
// clearing pass follows reset. Bytes beyond the committed count read as zero.
// depends on frbt_pkg, frbt_ifs, frbt_rx_ctrl
`default_nettype none

module framed_byte_receiver_with_timeout
  import frbt_pkg::*;
#(
  parameter int MAX_FRAME_LEN = 255
) (
  input  logic                 clk,
  input  logic                 rst_n,
  frbt_in_if.sink              in_ch,
  frbt_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  localparam int IDX_W     = $clog2(MAX_FRAME_LEN);
  localparam int MEM_DEPTH = 2 * (2 ** IDX_W);

  logic              in_fire;
  rx_wr_t            wr;
  rx_stat_t          stat;
  logic              rd_hit;

  logic [BYTE_W-1:0] mem [MEM_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;
  logic              rd_hit_r;
  logic              out_valid_r;
  logic              committed_r;
  logic [BYTE_W-1:0] count_r;
  logic              skip_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  frbt_rx_ctrl #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_rx_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .operation (in_ch.operation),
    .data_byte (in_ch.data_byte),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .wr        (wr),
    .stat      (stat)
  );

  assign rd_hit = (op_t'(in_ch.operation) == OP_READ) && (in_ch.read_index < stat.msg_count);

  always_ff @(posedge clk) begin
    if (wr.en) mem[{wr.bank, wr.idx[IDX_W-1:0]}] <= wr.data;
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data_r   <= mem[{stat.rd_bank, in_ch.read_index[IDX_W-1:0]}];
      rd_hit_r    <= rd_hit;
      committed_r <= stat.committed;
      count_r     <= stat.msg_count;
      skip_r      <= stat.skipping;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.read_data       = rd_hit_r ? rd_data_r : '0;
  assign out_ch.frame_committed = committed_r;
  assign out_ch.committed_count = count_r;
  assign out_ch.skipping        = skip_r;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid_r)
    else $error("accepted transaction produced no result");

  a_rd_data_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_ch.read_data) && $stable(rd_hit_r))
    else $error("memory read data changed while result stalled");

  a_no_write_read_bank: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> (wr.bank != stat.rd_bank))
    else $error("receive write hit the readable bank");

endmodule

`default_nettype wire
